[hw/rtl/bglc_pkg.sv]
// ----------------------------------------------------------------------------
// bglc_pkg
// Shared types, register codes and helpers of the battery gauge LED controller.
// ----------------------------------------------------------------------------
package bglc_pkg;

	localparam int CODE_W    = 8;
	localparam int HELD_W    = 9;
	localparam int LED_W     = 4;
	localparam int STEP_W    = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [HELD_W-1:0] LONG_PRESS = 9'd500;

	// item kinds
	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_BUTTON = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// gauge source
	typedef enum logic [1:0] {
		GK_NONE = 2'd0,
		GK_VOLT = 2'd1,
		GK_CURR = 2'd2,
		GK_RSVD = 2'd3
	} gauge_kind_t;

	// charge state, bits 4:3 of the charger status byte
	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_CHG_A = 2'd1,
		CS_CHG_B = 2'd2,
		CS_DONE  = 2'd3
	} charge_state_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UVLO   = 3'd0,
		CFG_VSTEP2 = 3'd1,
		CFG_VSTEP3 = 3'd2,
		CFG_VSTEP4 = 3'd3,
		CFG_CSTEP1 = 3'd4,
		CFG_CSTEP2 = 3'd5,
		CFG_CSTEP3 = 3'd6,
		CFG_CSTEP4 = 3'd7
	} cfg_reg_t;

	localparam logic [STEP_W-1:0] CHASE_LAST = 3'd4;
	localparam logic [LED_W-1:0]  LEDS_ALL   = 4'hF;
	localparam logic [LED_W-1:0]  LEDS_OFF   = 4'h0;

	typedef struct packed {
		logic [CODE_W-1:0] uvlo_code;
		logic [CODE_W-1:0] volt_step2_code;
		logic [CODE_W-1:0] volt_step3_code;
		logic [CODE_W-1:0] volt_step4_code;
		logic [CODE_W-1:0] curr_step1_code;
		logic [CODE_W-1:0] curr_step2_code;
		logic [CODE_W-1:0] curr_step3_code;
		logic [CODE_W-1:0] curr_step4_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		uvlo_code:       8'd35,
		volt_step2_code: 8'd55,
		volt_step3_code: 8'd75,
		volt_step4_code: 8'd85,
		curr_step1_code: 8'd1,
		curr_step2_code: 8'd10,
		curr_step3_code: 8'd20,
		curr_step4_code: 8'd30
	};

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] status_byte;
		logic [CODE_W-1:0] voltage_code;
		logic [CODE_W-1:0] current_code;
		logic [HELD_W-1:0] held_count;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0] leds;
		logic [LED_W-1:0] gauge;
		gauge_kind_t      gauge_kind;
		logic             shutdown;
	} result_t;

	typedef struct packed {
		charge_state_t     charge_state;
		logic [CODE_W-1:0] volt_level;
		logic [CODE_W-1:0] curr_level;
		logic [STEP_W-1:0] chase_step;
		logic [LED_W-1:0]  led_bits;
		logic              chase_enable;
	} state_t;

	// thermometer bar over four ascending thresholds
	function automatic logic [LED_W-1:0] bar4(
		input logic [CODE_W-1:0] v,
		input logic [CODE_W-1:0] t1,
		input logic [CODE_W-1:0] t2,
		input logic [CODE_W-1:0] t3,
		input logic [CODE_W-1:0] t4
	);
		logic [LED_W-1:0] bar;
		if (v >= t4) begin
			bar = 4'hF;
		end else if (v >= t3) begin
			bar = 4'h7;
		end else if (v >= t2) begin
			bar = 4'h3;
		end else if (v >= t1) begin
			bar = 4'h1;
		end else begin
			bar = 4'h0;
		end
		return bar;
	endfunction

endpackage

[hw/rtl/bglc_if.sv]
// ----------------------------------------------------------------------------
// bglc_if
// Valid/ready channels of the battery gauge LED controller: item and result.
// ----------------------------------------------------------------------------
interface bglc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  status_byte;
	logic [7:0]  voltage_code;
	logic [7:0]  current_code;
	logic [8:0]  held_count;

	modport source (
		output valid, kind, status_byte, voltage_code, current_code, held_count,
		input  ready
	);
	modport sink (
		input  valid, kind, status_byte, voltage_code, current_code, held_count,
		output ready
	);
endinterface

interface bglc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  leds;
	logic [3:0]  gauge;
	logic [1:0]  gauge_kind;
	logic        shutdown;

	modport source (
		output valid, leds, gauge, gauge_kind, shutdown,
		input  ready
	);
	modport sink (
		input  valid, leds, gauge, gauge_kind, shutdown,
		output ready
	);
endinterface

[hw/rtl/battery_gauge_led_controller.sv]
// ----------------------------------------------------------------------------
// battery_gauge_led_controller
// Power-bank LED controller on raw charger codes: UVLO, chase, bar gauge.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready sink. One beat is a charger sample, a chase tick or
//             a button release (kind), with the raw status, voltage and
//             current codes and the button hold count.
//   results : valid/ready source. Exactly one beat per item: LED states,
//             gauge bar and its source, and a shutdown request.
//   cfg_*   : plain write port for the eight threshold codes; write only
//             while the block is idle.
// Path: an accepted item passes the input register, then the update logic
//   feeding the result register and the state registers.
// Throughput: one item per cycle while results is ready; the only loop is
//   the state register, updated in the same cycle that the result register loads.
// Reset: thresholds go to their defaults, LEDs off, chase disabled and
//   parked at step 0, latched levels zero; both stages empty.
// Stall: while results is held off the result register keeps its beat and
//   the input register still takes one more item; after that items.ready
//   drops until the result beat leaves.
// ----------------------------------------------------------------------------
module battery_gauge_led_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	bglc_in_if.sink                           items,
	bglc_out_if.source                        results,
	input  logic                              cfg_we,
	input  logic [bglc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bglc_pkg::CODE_W-1:0]       cfg_data
);

	bglc_pkg::cfg_t    cfg_q;
	bglc_pkg::state_t  state_q;
	bglc_pkg::state_t  state_nxt;
	bglc_pkg::item_t   item_s1;
	bglc_pkg::result_t result_q;
	bglc_pkg::result_t result_nxt;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;
	logic              in_accept;

	// result register frees up when empty or when its beat is taken
	assign advance      = !out_valid_q || results.ready;
	assign items.ready  = !valid_s1 || advance;
	assign in_accept    = items.valid && items.ready;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bglc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (bglc_pkg::cfg_reg_t'(cfg_idx))
				bglc_pkg::CFG_UVLO:   cfg_q.uvlo_code       <= cfg_data;
				bglc_pkg::CFG_VSTEP2: cfg_q.volt_step2_code <= cfg_data;
				bglc_pkg::CFG_VSTEP3: cfg_q.volt_step3_code <= cfg_data;
				bglc_pkg::CFG_VSTEP4: cfg_q.volt_step4_code <= cfg_data;
				bglc_pkg::CFG_CSTEP1: cfg_q.curr_step1_code <= cfg_data;
				bglc_pkg::CFG_CSTEP2: cfg_q.curr_step2_code <= cfg_data;
				bglc_pkg::CFG_CSTEP3: cfg_q.curr_step3_code <= cfg_data;
				bglc_pkg::CFG_CSTEP4: cfg_q.curr_step4_code <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.kind         <= bglc_pkg::kind_t'(items.kind);
			item_s1.status_byte  <= items.status_byte;
			item_s1.voltage_code <= items.voltage_code;
			item_s1.current_code <= items.current_code;
			item_s1.held_count   <= items.held_count;
		end
	end

	// update logic
	bglc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (result_nxt)
	);

	// stage 2: controller state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_nxt;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.leds       = result_q.leds;
	assign results.gauge      = result_q.gauge;
	assign results.gauge_kind = result_q.gauge_kind;
	assign results.shutdown   = result_q.shutdown;

	// chase step never runs past the wrap point
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.chase_step <= (bglc_pkg::CHASE_LAST + 3'd1))
		else $error("chase step out of range");

	// a shutdown beat never carries a gauge
	a_shut_no_gauge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.shutdown |->
			result_q.gauge == bglc_pkg::LEDS_OFF && result_q.gauge_kind == bglc_pkg::GK_NONE)
		else $error("shutdown beat with gauge");

	// no gauge source means an empty bar
	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.gauge_kind == bglc_pkg::GK_NONE |->
			result_q.gauge == bglc_pkg::LEDS_OFF)
		else $error("bar shown without source");

	// a held input stage blocks new items
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !items.ready)
		else $error("item taken while both stages full");

	// every processed item lands in the result register
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("item lost between stages");

endmodule

[hw/rtl/bglc_step.sv]
// ----------------------------------------------------------------------------
// bglc_step
// One item's update: next controller state and the result beat.
// ----------------------------------------------------------------------------
module bglc_step (
	input  bglc_pkg::cfg_t   cfg,
	input  bglc_pkg::state_t cur,
	input  bglc_pkg::item_t  item,
	output bglc_pkg::state_t nxt,
	output bglc_pkg::result_t res
);

	always_comb begin
		nxt            = cur;
		res.gauge      = bglc_pkg::LEDS_OFF;
		res.gauge_kind = bglc_pkg::GK_NONE;
		res.shutdown   = 1'b0;

		unique case (item.kind)
			bglc_pkg::KIND_SAMPLE: begin
				nxt.charge_state = bglc_pkg::charge_state_t'(item.status_byte[4:3]);
				nxt.volt_level   = item.voltage_code;
				nxt.curr_level   = item.current_code;
				if (item.voltage_code < cfg.uvlo_code) begin
					res.shutdown = 1'b1;
					nxt.led_bits = bglc_pkg::LEDS_OFF;
				end
				priority case (nxt.charge_state)
					bglc_pkg::CS_DONE: begin
						nxt.chase_enable = 1'b0;
						nxt.led_bits     = bglc_pkg::LEDS_ALL;
					end
					bglc_pkg::CS_IDLE: begin
						nxt.chase_enable = 1'b0;
						nxt.chase_step   = '0;
						nxt.led_bits     = bglc_pkg::LEDS_OFF;
					end
					default: begin
						nxt.chase_enable = 1'b1;
					end
				endcase
			end
			bglc_pkg::KIND_TICK: begin
				if (cur.chase_enable) begin
					// one LED per step, gated by the latched voltage
					if (cur.chase_step == 3'd1 && cur.volt_level >= cfg.uvlo_code) begin
						nxt.led_bits = cur.led_bits | 4'b0001;
					end else if (cur.chase_step == 3'd2
						&& cur.volt_level >= cfg.volt_step2_code) begin
						nxt.led_bits = cur.led_bits | 4'b0010;
					end else if (cur.chase_step == 3'd3
						&& cur.volt_level >= cfg.volt_step3_code) begin
						nxt.led_bits = cur.led_bits | 4'b0100;
					end else if (cur.chase_step == 3'd4
						&& cur.volt_level >= cfg.volt_step4_code) begin
						nxt.led_bits = cur.led_bits | 4'b1000;
					end
					// wrap: past the last LED the bar restarts dark at step one
					if (cur.chase_step > bglc_pkg::CHASE_LAST) begin
						nxt.chase_step = 3'd1;
						nxt.led_bits   = bglc_pkg::LEDS_OFF;
					end else begin
						nxt.chase_step = cur.chase_step + 3'd1;
					end
				end
			end
			bglc_pkg::KIND_BUTTON: begin
				nxt.chase_step   = '0;
				nxt.charge_state = bglc_pkg::charge_state_t'(item.status_byte[4:3]);
				nxt.volt_level   = item.voltage_code;
				nxt.curr_level   = item.current_code;
				nxt.led_bits     = bglc_pkg::LEDS_OFF;
				if (item.held_count > bglc_pkg::LONG_PRESS) begin
					res.shutdown = 1'b1;
				end else if (nxt.charge_state == bglc_pkg::CS_IDLE
					|| nxt.charge_state == bglc_pkg::CS_DONE) begin
					res.gauge_kind = bglc_pkg::GK_VOLT;
					res.gauge      = bglc_pkg::bar4(item.voltage_code, cfg.uvlo_code,
						cfg.volt_step2_code, cfg.volt_step3_code, cfg.volt_step4_code);
				end else begin
					res.gauge_kind = bglc_pkg::GK_CURR;
					res.gauge      = bglc_pkg::bar4(item.current_code, cfg.curr_step1_code,
						cfg.curr_step2_code, cfg.curr_step3_code, cfg.curr_step4_code);
				end
			end
			default: begin
				// unused kind: state holds, LEDs echoed
			end
		endcase

		res.leds = nxt.led_bits;
	end

endmodule

[sim/tb_battery_gauge_led_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_gauge_led_controller
// Self-checking bench for the power-bank LED controller. It mirrors the LED,
// chase and gauge state in a small tracker, predicts one result beat per
// accepted item and compares each result beat field by field. Stimulus is a
// directed warm-up followed by random charger sessions, run under several
// threshold settings, with random gaps on both channels and two long output
// stalls that back up the input side.
// ----------------------------------------------------------------------------
module tb_battery_gauge_led_controller;

	// Tracks the controller's LEDs, chase and latched sample, and keeps
	// the results still owed by the block, oldest first.
	class led_panel_tracker;
		bglc_pkg::cfg_t              thr       = bglc_pkg::CFG_RESET;
		bglc_pkg::charge_state_t     chg       = bglc_pkg::CS_IDLE;
		logic [bglc_pkg::CODE_W-1:0] volt      = '0;
		logic [bglc_pkg::CODE_W-1:0] curr      = '0;
		logic [bglc_pkg::STEP_W-1:0] chase_pos = '0;
		logic [bglc_pkg::LED_W-1:0]  lit       = bglc_pkg::LEDS_OFF;
		logic                        chase_on  = 1'b0;
		bglc_pkg::result_t           panels_due[$];
		int                          errors    = 0;

		function void set_threshold(bglc_pkg::cfg_reg_t r,
				logic [bglc_pkg::CODE_W-1:0] v);
			case (r)
				bglc_pkg::CFG_UVLO:   thr.uvlo_code       = v;
				bglc_pkg::CFG_VSTEP2: thr.volt_step2_code = v;
				bglc_pkg::CFG_VSTEP3: thr.volt_step3_code = v;
				bglc_pkg::CFG_VSTEP4: thr.volt_step4_code = v;
				bglc_pkg::CFG_CSTEP1: thr.curr_step1_code = v;
				bglc_pkg::CFG_CSTEP2: thr.curr_step2_code = v;
				bglc_pkg::CFG_CSTEP3: thr.curr_step3_code = v;
				bglc_pkg::CFG_CSTEP4: thr.curr_step4_code = v;
				default: ;
			endcase
		endfunction

		// highest threshold reached wins, even when thresholds are out of order
		function logic [bglc_pkg::LED_W-1:0] bar_level(logic [bglc_pkg::CODE_W-1:0] v,
				logic [bglc_pkg::CODE_W-1:0] t1, logic [bglc_pkg::CODE_W-1:0] t2,
				logic [bglc_pkg::CODE_W-1:0] t3, logic [bglc_pkg::CODE_W-1:0] t4);
			logic [bglc_pkg::CODE_W-1:0] t [4];
			t[0] = t1;
			t[1] = t2;
			t[2] = t3;
			t[3] = t4;
			for (int i = 3; i >= 0; i--) begin
				if (v >= t[i]) return bglc_pkg::LEDS_ALL >> (3 - i);
			end
			return bglc_pkg::LEDS_OFF;
		endfunction

		function void latch(bglc_pkg::item_t it);
			chg  = bglc_pkg::charge_state_t'(it.status_byte[4:3]);
			volt = it.voltage_code;
			curr = it.current_code;
		endfunction

		function void accept_item(bglc_pkg::item_t it);
			bglc_pkg::result_t r;
			r = '0;
			case (it.kind)
				bglc_pkg::KIND_SAMPLE: begin
					latch(it);
					if (volt < thr.uvlo_code) begin
						r.shutdown = 1'b1;
						lit = bglc_pkg::LEDS_OFF;
					end
					if (chg == bglc_pkg::CS_DONE) begin
						chase_on = 1'b0;
						lit = bglc_pkg::LEDS_ALL;
					end else if (chg == bglc_pkg::CS_IDLE) begin
						chase_on = 1'b0;
						chase_pos = '0;
						lit = bglc_pkg::LEDS_OFF;
					end else begin
						chase_on = 1'b1;
					end
				end
				bglc_pkg::KIND_TICK: begin
					if (chase_on) begin
						case (chase_pos)
							3'd1: if (volt >= thr.uvlo_code) lit[0] = 1'b1;
							3'd2: if (volt >= thr.volt_step2_code) lit[1] = 1'b1;
							3'd3: if (volt >= thr.volt_step3_code) lit[2] = 1'b1;
							3'd4: if (volt >= thr.volt_step4_code) lit[3] = 1'b1;
							default: ;
						endcase
						if (chase_pos > bglc_pkg::CHASE_LAST) begin
							chase_pos = '0;
							lit = bglc_pkg::LEDS_OFF;
						end
						chase_pos = chase_pos + 1'b1;
					end
				end
				bglc_pkg::KIND_BUTTON: begin
					chase_pos = '0;
					latch(it);
					if (it.held_count > bglc_pkg::LONG_PRESS) begin
						r.shutdown = 1'b1;
					end else if (chg == bglc_pkg::CS_IDLE || chg == bglc_pkg::CS_DONE) begin
						r.gauge_kind = bglc_pkg::GK_VOLT;
						r.gauge = bar_level(volt, thr.uvlo_code, thr.volt_step2_code,
							thr.volt_step3_code, thr.volt_step4_code);
					end else begin
						r.gauge_kind = bglc_pkg::GK_CURR;
						r.gauge = bar_level(curr, thr.curr_step1_code, thr.curr_step2_code,
							thr.curr_step3_code, thr.curr_step4_code);
					end
					lit = bglc_pkg::LEDS_OFF;
				end
				default: ;
			endcase
			r.leds = lit;
			panels_due.push_back(r);
		endfunction

		function int outstanding();
			return panels_due.size();
		endfunction

		function void compare_panel(bglc_pkg::result_t got);
			bglc_pkg::result_t want;
			if (panels_due.size() == 0) begin
				$error("result beat with nothing pending: leds %0d gauge %0d", got.leds, got.gauge);
				errors++;
				return;
			end
			want = panels_due.pop_front();
			if (got.leds !== want.leds) begin
				$error("leds: expected %0d, got %0d", want.leds, got.leds);
				errors++;
			end
			if (got.gauge !== want.gauge) begin
				$error("gauge: expected %0d, got %0d", want.gauge, got.gauge);
				errors++;
			end
			if (got.gauge_kind !== want.gauge_kind) begin
				$error("gauge_kind: expected %0d, got %0d", want.gauge_kind, got.gauge_kind);
				errors++;
			end
			if (got.shutdown !== want.shutdown) begin
				$error("shutdown: expected %0d, got %0d", want.shutdown, got.shutdown);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bglc_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [bglc_pkg::CODE_W-1:0]    cfg_data;

	bglc_in_if  items_ch ();
	bglc_out_if results_ch ();

	led_panel_tracker board = new;

	// threshold set loaded by program_thresholds, indexed by register
	logic [bglc_pkg::CODE_W-1:0] thr_set [8];

	// set by the stimulus to ask the receiver for one long hold-off
	bit squeeze_req = 1'b0;

	always #6 clk = ~clk;

	battery_gauge_led_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Result side: every beat taken is checked against the oldest prediction.
	always @(posedge clk) begin : watch_results
		bglc_pkg::result_t got;
		if (results_ch.valid && results_ch.ready) begin
			got.leds       = results_ch.leds;
			got.gauge      = results_ch.gauge;
			got.gauge_kind = bglc_pkg::gauge_kind_t'(results_ch.gauge_kind);
			got.shutdown   = results_ch.shutdown;
			board.compare_panel(got);
		end
	end

	// Receiver: ready runs of random length, short and occasional long stalls.
	// A squeeze request turns into one long hold-off so that both stages fill
	// and items.ready drops while the sender keeps offering beats.
	initial begin : receiver
		int run;
		int hold;
		int r;
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			results_ch.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 99);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = 150;
			end else if (r < 70) begin
				hold = 0;
			end else if (r < 95) begin
				hold = $urandom_range(1, 4);
			end else begin
				hold = $urandom_range(10, 40);
			end
			if (hold > 0) begin
				results_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Offer one beat and hold it until taken; returns at the accepting edge.
	task automatic send_item(input bglc_pkg::kind_t k,
			input logic [bglc_pkg::CODE_W-1:0] st,
			input logic [bglc_pkg::CODE_W-1:0] v, input logic [bglc_pkg::CODE_W-1:0] c,
			input logic [bglc_pkg::HELD_W-1:0] h);
		bglc_pkg::item_t it;
		it.kind         = k;
		it.status_byte  = st;
		it.voltage_code = v;
		it.current_code = c;
		it.held_count   = h;
		items_ch.valid        <= 1'b1;
		items_ch.kind         <= k;
		items_ch.status_byte  <= st;
		items_ch.voltage_code <= v;
		items_ch.current_code <= c;
		items_ch.held_count   <= h;
		do @(posedge clk); while (!items_ch.ready);
		board.accept_item(it);
	endtask

	// Sender gap after a beat: mostly none, some short, a few long.
	task automatic pause_sender(input bit dense);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (dense || r < 70) begin
			gap = 0;
		end else if (r < 93) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every predicted result has come back, plus a little slack.
	task automatic drain();
		items_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all eight thresholds from thr_set; block must be idle.
	task automatic program_thresholds();
		bglc_pkg::cfg_reg_t r;
		r = bglc_pkg::CFG_UVLO;
		repeat (8) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= r;
			cfg_data <= thr_set[r];
			@(posedge clk);
			board.set_threshold(r, thr_set[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// code within two steps of t, clipped to the code range
	function automatic logic [bglc_pkg::CODE_W-1:0] near(
			input logic [bglc_pkg::CODE_W-1:0] t);
		int v;
		v = int'(t) + $urandom_range(0, 4) - 2;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[bglc_pkg::CODE_W-1:0];
	endfunction

	// voltage codes cluster around the active thresholds so every bar edge is hit
	function automatic logic [bglc_pkg::CODE_W-1:0] volt_probe();
		case ($urandom_range(0, 5))
			0: return near(board.thr.uvlo_code);
			1: return near(board.thr.volt_step2_code);
			2: return near(board.thr.volt_step3_code);
			3: return near(board.thr.volt_step4_code);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [bglc_pkg::CODE_W-1:0] curr_probe();
		case ($urandom_range(0, 5))
			0: return near(board.thr.curr_step1_code);
			1: return near(board.thr.curr_step2_code);
			2: return near(board.thr.curr_step3_code);
			3: return near(board.thr.curr_step4_code);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random charger sessions: mostly charging samples followed by chase ticks,
	// with button presses, idle/done samples and a few unused kinds mixed in.
	task automatic run_random(input int count);
		bglc_pkg::kind_t             k;
		logic [bglc_pkg::CODE_W-1:0] st;
		logic [bglc_pkg::HELD_W-1:0] h;
		int                          r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				k = bglc_pkg::KIND_TICK;
			end else if (r < 75) begin
				k = bglc_pkg::KIND_SAMPLE;
			end else if (r < 95) begin
				k = bglc_pkg::KIND_BUTTON;
			end else begin
				k = bglc_pkg::KIND_UNUSED;
			end
			st = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 9);
			if (r < 3) begin
				st[4:3] = bglc_pkg::CS_CHG_A;
			end else if (r < 6) begin
				st[4:3] = bglc_pkg::CS_CHG_B;
			end else if (r < 8) begin
				st[4:3] = bglc_pkg::CS_IDLE;
			end else begin
				st[4:3] = bglc_pkg::CS_DONE;
			end
			// long press is any count above 500; 500 is the last short one
			r = $urandom_range(0, 9);
			if (r == 0) begin
				h = 9'd501;
			end else if (r == 1) begin
				h = 9'd500;
			end else begin
				h = 9'($urandom_range(0, 501));
			end
			send_item(k, st, volt_probe(), curr_probe(), h);
			// first 40 beats of every 200 go back to back
			pause_sender((n % 200) < 40);
		end
	endtask

	initial begin : stimulus
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_idx               <= bglc_pkg::CFG_UVLO;
		cfg_data              <= '0;
		items_ch.valid        <= 1'b0;
		items_ch.kind         <= bglc_pkg::KIND_SAMPLE;
		items_ch.status_byte  <= '0;
		items_ch.voltage_code <= '0;
		items_ch.current_code <= '0;
		items_ch.held_count   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed warm-up at default thresholds ---
		// tick with the chase still disabled, then the unused kind with all ones
		send_item(bglc_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 9'd0);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 9'd501);
		pause_sender(1'b0);
		// idle at zero volts: UVLO shutdown; done at full scale; done under UVLO
		send_item(bglc_pkg::KIND_SAMPLE, 8'h00, 8'd0, 8'd0, 9'd0);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_SAMPLE, 8'h18, 8'd255, 8'd255, 9'd0);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_SAMPLE, 8'h18, 8'd34, 8'd3, 9'd0);
		pause_sender(1'b0);
		// idle with other status bits set clears everything
		send_item(bglc_pkg::KIND_SAMPLE, 8'hE7, 8'd100, 8'd0, 9'd0);
		pause_sender(1'b0);
		// charging above every voltage step: chase lights all four, then wraps
		send_item(bglc_pkg::KIND_SAMPLE, 8'h08, 8'd90, 8'd25, 9'd0);
		pause_sender(1'b0);
		repeat (7) begin
			send_item(bglc_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00, 9'd0);
			pause_sender(1'b0);
		end
		// charging between step 2 and step 3: upper LEDs stay dark
		send_item(bglc_pkg::KIND_SAMPLE, 8'hF7, 8'd60, 8'd15, 9'd0);
		pause_sender(1'b0);
		repeat (5) begin
			send_item(bglc_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 9'd511);
			pause_sender(1'b0);
		end
		// buttons: longest short press, long press, then each gauge flavor
		send_item(bglc_pkg::KIND_BUTTON, 8'h08, 8'd60, 8'd30, 9'd500);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_BUTTON, 8'h08, 8'd60, 8'd30, 9'd501);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_BUTTON, 8'h00, 8'd35, 8'd0, 9'd0);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_BUTTON, 8'h18, 8'd84, 8'd0, 9'd255);
		pause_sender(1'b0);
		send_item(bglc_pkg::KIND_BUTTON, 8'h10, 8'd200, 8'd0, 9'd1);
		pause_sender(1'b0);
		drain();

		// --- random phases under several threshold sets ---
		// defaults, with the long output stall early on
		squeeze_req = 1'b1;
		run_random(250);
		drain();

		// every threshold at zero: no UVLO, every bar full
		foreach (thr_set[i]) thr_set[i] = 8'd0;
		program_thresholds();
		run_random(250);
		drain();

		// every threshold at full scale
		foreach (thr_set[i]) thr_set[i] = 8'd255;
		program_thresholds();
		squeeze_req = 1'b1;
		run_random(250);
		drain();

		// descending order: higher levels win before lower ones are reached
		thr_set[bglc_pkg::CFG_UVLO]   = 8'd200;
		thr_set[bglc_pkg::CFG_VSTEP2] = 8'd150;
		thr_set[bglc_pkg::CFG_VSTEP3] = 8'd100;
		thr_set[bglc_pkg::CFG_VSTEP4] = 8'd50;
		thr_set[bglc_pkg::CFG_CSTEP1] = 8'd40;
		thr_set[bglc_pkg::CFG_CSTEP2] = 8'd30;
		thr_set[bglc_pkg::CFG_CSTEP3] = 8'd20;
		thr_set[bglc_pkg::CFG_CSTEP4] = 8'd10;
		program_thresholds();
		run_random(250);
		drain();

		// fully random thresholds
		foreach (thr_set[i]) thr_set[i] = 8'($urandom_range(0, 255));
		program_thresholds();
		run_random(250);
		drain();

		// back to the documented defaults
		thr_set[bglc_pkg::CFG_UVLO]   = bglc_pkg::CFG_RESET.uvlo_code;
		thr_set[bglc_pkg::CFG_VSTEP2] = bglc_pkg::CFG_RESET.volt_step2_code;
		thr_set[bglc_pkg::CFG_VSTEP3] = bglc_pkg::CFG_RESET.volt_step3_code;
		thr_set[bglc_pkg::CFG_VSTEP4] = bglc_pkg::CFG_RESET.volt_step4_code;
		thr_set[bglc_pkg::CFG_CSTEP1] = bglc_pkg::CFG_RESET.curr_step1_code;
		thr_set[bglc_pkg::CFG_CSTEP2] = bglc_pkg::CFG_RESET.curr_step2_code;
		thr_set[bglc_pkg::CFG_CSTEP3] = bglc_pkg::CFG_RESET.curr_step3_code;
		thr_set[bglc_pkg::CFG_CSTEP4] = bglc_pkg::CFG_RESET.curr_step4_code;
		program_thresholds();
		run_random(250);
		drain();
		repeat (5) @(posedge clk);

		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
